// ----- rtl/core/minhash_token_ngram_signature_assert.svh -----
// assertion macros used by the minhash signature back end
`ifndef MINHASH_TOKEN_NGRAM_SIGNATURE_ASSERT_SVH
`define MINHASH_TOKEN_NGRAM_SIGNATURE_ASSERT_SVH

// condition implies consequence in the same cycle
`define MTNS_ASSERT_NOW(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define MTNS_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/mtns_pkg.sv -----
// package with types, constants and hash helpers for the minhash signature block
`default_nettype none
package mtns_pkg;

    localparam int DEF_HASH_LANES = 64;
    localparam int DEF_MAX_NGRAM  = 8;

    localparam int TOKEN_W   = 32;
    localparam int ENTRY_W   = 6;
    localparam int COUNT_W   = 7;
    localparam int WINDOW_W  = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [31:0] MUR_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MUR_C2 = 32'h1b873593;
    localparam logic [31:0] MUR_N  = 32'he6546b64;
    localparam logic [31:0] MUR_F1 = 32'h85ebca6b;
    localparam logic [31:0] MUR_F2 = 32'hc2b2ae35;

    typedef enum logic [1:0] {
        REQ_TOKEN   = 2'd0,
        REQ_DOC_END = 2'd1,
        REQ_READ    = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        CFG_HASH_SEED     = 2'd0,
        CFG_HASH_COUNT    = 2'd1,
        CFG_WINDOW_TOKENS = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3,
        ST_READ
    } back_state_t;

    typedef struct packed {
        logic init;
        logic fold;
        logic fin1;
        logic fin2;
        logic fin3;
        logic clear;
    } cell_ctrl_t;

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        rotl15 = {x[16:0], x[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] x);
        rotl13 = {x[18:0], x[31:19]};
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        mul32 = p[31:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mtns_if.sv -----
// request and response channel interfaces
`default_nettype none
interface mtns_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] token;
    modport source (output valid, output req_type, output token, input ready);
    modport sink (input valid, input req_type, input token, output ready);
endinterface

interface mtns_rsp_if;
    logic        valid;
    logic        ready;
    logic [5:0]  entry_index;
    logic [31:0] min_value;
    logic        last_entry;
    modport source (output valid, output entry_index, output min_value, output last_entry,
                    input ready);
    modport sink (input valid, input entry_index, input min_value, input last_entry,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mtns_front.sv -----
// front end: accepts requests, premixes tokens, keeps the window, issues commands
`default_nettype none
module mtns_front #(
    parameter int MAX_NGRAM = mtns_pkg::DEF_MAX_NGRAM,
    parameter int N_W       = $clog2(MAX_NGRAM + 1),
    parameter int CMD_W     = 2 + N_W + MAX_NGRAM * 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    mtns_req_if.sink                           req,
    input  wire logic [mtns_pkg::WINDOW_W-1:0] window_tokens,
    output logic                               cmd_valid,
    input  wire logic                          cmd_ready,
    output logic [CMD_W-1:0]                   cmd_data
);
    import mtns_pkg::*;

    logic        s0_valid_reg;
    req_kind_t   s0_kind_reg;
    logic [31:0] s0_k1_reg;
    logic [31:0] win_reg [MAX_NGRAM];
    logic [31:0] win_next [MAX_NGRAM];
    logic [N_W-1:0] fill_reg;
    logic [N_W-1:0] fill_inc;
    logic [N_W-1:0] n_act;
    logic        is_tok;
    logic        need_push;
    logic        s0_go;
    logic [31:0] kmix;
    logic [MAX_NGRAM*32-1:0] win_flat;

    always_comb
    begin
        if (window_tokens == '0)
            n_act = N_W'(1);
        else if (32'(window_tokens) > MAX_NGRAM)
            n_act = N_W'(MAX_NGRAM);
        else
            n_act = N_W'(window_tokens);
    end

    assign kmix     = mul32(rotl15(s0_k1_reg), MUR_C2);
    assign fill_inc = (fill_reg == N_W'(MAX_NGRAM)) ? fill_reg : fill_reg + 1'b1;

    always_comb
    begin
        unique case (s0_kind_reg) inside
            REQ_TOKEN, REQ_DOC_END: is_tok = 1'b1;
            default:                is_tok = 1'b0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < MAX_NGRAM - 1; i++)
            win_next[i] = win_reg[i + 1];
        win_next[MAX_NGRAM - 1] = kmix;
        for (int i = 0; i < MAX_NGRAM; i++)
            win_flat[i*32 +: 32] = win_next[i];
    end

    assign need_push = is_tok ? (fill_inc >= n_act) : 1'b1;
    assign s0_go     = s0_valid_reg && (!need_push || cmd_ready);
    assign req.ready = !s0_valid_reg || s0_go;
    assign cmd_valid = s0_valid_reg && need_push;
    assign cmd_data  = {s0_kind_reg, n_act, win_flat};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            fill_reg     <= '0;
        end
        else
        begin
            if (req.ready)
                s0_valid_reg <= req.valid;
            if (s0_go && is_tok)
                fill_reg <= (s0_kind_reg == REQ_DOC_END) ? '0 : fill_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s0_kind_reg <= req_kind_t'(req.req_type);
            s0_k1_reg   <= mul32(req.token, MUR_C1);
        end
        if (s0_go && is_tok)
            win_reg <= win_next;
    end

endmodule
`default_nettype wire

// ----- rtl/core/mtns_cmd_fifo.sv -----
// two-entry command queue between front and back
`default_nettype none
module mtns_cmd_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// ----- rtl/core/mtns_cell.sv -----
// one hash cell: folds the window, finalizes and keeps the running minimum
`default_nettype none
module mtns_cell #(
    parameter int J = 0
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mtns_pkg::cell_ctrl_t         ctrl,
    input  wire logic [31:0]                  k,
    input  wire logic [31:0]                  seed,
    input  wire logic [31:0]                  len,
    input  wire logic [mtns_pkg::COUNT_W-1:0] cnt,
    output logic [31:0]                       sig
);
    import mtns_pkg::*;

    logic [31:0] h_reg;
    logic [31:0] sig_reg;
    logic [31:0] r;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        active;

    assign r      = rotl13(h_reg ^ k);
    assign x      = (h_reg ^ len) ^ ((h_reg ^ len) >> 16);
    assign y      = h_reg ^ (h_reg >> 13);
    assign z      = h_reg ^ (h_reg >> 16);
    assign active = (32'(J) < 32'(cnt));
    assign sig    = sig_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.init)
            h_reg <= seed + 32'(J);
        else if (ctrl.fold)
            h_reg <= {r[29:0], 2'b00} + r + MUR_N;
        else if (ctrl.fin1)
            h_reg <= mul32(x, MUR_F1);
        else if (ctrl.fin2)
            h_reg <= mul32(y, MUR_F2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sig_reg <= '1;
        else if (ctrl.clear)
            sig_reg <= '1;
        else if (ctrl.fin3 && active && (z < sig_reg))
            sig_reg <= z;
    end

endmodule
`default_nettype wire

// ----- rtl/core/mtns_back.sv -----
// back end: sequences the hash cells and streams the signature readout
`default_nettype none
`include "minhash_token_ngram_signature_assert.svh"
module mtns_back #(
    parameter int HASH_LANES = mtns_pkg::DEF_HASH_LANES,
    parameter int MAX_NGRAM  = mtns_pkg::DEF_MAX_NGRAM,
    parameter int N_W        = $clog2(MAX_NGRAM + 1),
    parameter int CMD_W      = 2 + N_W + MAX_NGRAM * 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_pop,
    input  wire logic [CMD_W-1:0]              cmd_data,
    input  wire logic [mtns_pkg::COUNT_W-1:0]  hash_count,
    input  wire logic [31:0]                   sig [HASH_LANES],
    output mtns_pkg::cell_ctrl_t               ctrl,
    output logic [31:0]                        k,
    output logic [31:0]                        len,
    output logic [mtns_pkg::COUNT_W-1:0]       cnt,
    mtns_rsp_if.source                         rsp
);
    import mtns_pkg::*;

    localparam int IDX_W = (MAX_NGRAM > 1) ? $clog2(MAX_NGRAM) : 1;
    localparam int J_W   = (HASH_LANES > 1) ? $clog2(HASH_LANES) : 1;

    back_state_t    state_reg;
    back_state_t    state_next;
    logic [31:0]    kw_reg [MAX_NGRAM];
    logic [IDX_W-1:0] idx_reg;
    logic [N_W-1:0] n_reg;
    logic [J_W-1:0] rd_j_reg;
    logic           rsp_valid_reg;
    logic [ENTRY_W-1:0] rsp_index_reg;
    logic [31:0]    rsp_value_reg;
    logic           rsp_last_reg;
    req_kind_t      cmd_kind;
    logic [N_W-1:0] cmd_n;
    logic           load;
    logic           rd_last;
    logic           fold_end;

    assign cmd_kind = req_kind_t'(cmd_data[CMD_W-1 -: 2]);
    assign cmd_n    = cmd_data[MAX_NGRAM*32 +: N_W];

    always_comb
    begin
        if (hash_count == '0)
            cnt = COUNT_W'(1);
        else if (32'(hash_count) > HASH_LANES)
            cnt = COUNT_W'(HASH_LANES);
        else
            cnt = hash_count;
    end

    assign k        = kw_reg[idx_reg];
    assign len      = 32'(n_reg) << 2;
    assign fold_end = (idx_reg == IDX_W'(MAX_NGRAM - 1));
    assign load     = (state_reg == ST_READ) && (!rsp_valid_reg || rsp.ready);
    assign rd_last  = (COUNT_W'(rd_j_reg) + COUNT_W'(1) == cnt);

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.entry_index = rsp_index_reg;
    assign rsp.min_value   = rsp_value_reg;
    assign rsp.last_entry  = rsp_last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd_kind) inside
                        REQ_TOKEN, REQ_DOC_END: state_next = ST_FOLD;
                        REQ_READ:               state_next = ST_READ;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FOLD: if (fold_end) state_next = ST_FIN1;
            ST_FIN1: state_next = ST_FIN2;
            ST_FIN2: state_next = ST_FIN3;
            ST_FIN3: state_next = ST_IDLE;
            ST_READ: if (load && rd_last) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl    = '0;
        cmd_pop = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_pop = cmd_valid;
                if (cmd_valid)
                begin
                    ctrl.init  = (cmd_kind == REQ_TOKEN) || (cmd_kind == REQ_DOC_END);
                    ctrl.clear = (cmd_kind == REQ_CLEAR);
                end
            end
            ST_FOLD: ctrl.fold = 1'b1;
            ST_FIN1: ctrl.fin1 = 1'b1;
            ST_FIN2: ctrl.fin2 = 1'b1;
            ST_FIN3: ctrl.fin3 = 1'b1;
            default: ctrl      = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            rd_j_reg      <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
            if (state_reg == ST_IDLE)
                rd_j_reg <= '0;
            else if (load)
                rd_j_reg <= rd_j_reg + 1'b1;
            if (ctrl.init)
                idx_reg <= IDX_W'(MAX_NGRAM - 32'(cmd_n));
            else if (ctrl.fold && !fold_end)
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            n_reg <= cmd_n;
            for (int i = 0; i < MAX_NGRAM; i++)
                kw_reg[i] <= cmd_data[i*32 +: 32];
        end
        if (load)
        begin
            rsp_index_reg <= ENTRY_W'(rd_j_reg);
            rsp_value_reg <= sig[rd_j_reg];
            rsp_last_reg  <= rd_last;
        end
    end

    `MTNS_ASSERT_NOW(a_pop_idle, cmd_pop, state_reg == ST_IDLE, "command taken while busy")
    `MTNS_ASSERT_NEXT(a_fin_order, state_reg == ST_FIN1, state_reg == ST_FIN2, "fin order")
    `MTNS_ASSERT_NOW(a_read_range, state_reg == ST_READ, COUNT_W'(rd_j_reg) < cnt, "read range")

endmodule
`default_nettype wire

// ----- rtl/core/minhash_token_ngram_signature.sv -----
// top level of the minhash token n-gram signature block
// usage:
//   req channel carries req_type and token; token and document-end requests
//   advance the n-gram window, read requests stream the signature, clear
//   requests reset every entry to all ones.
//   rsp channel returns one transfer per active entry on a read, entry_index
//   ascending, last_entry set on the final one.
//   config writes (cfg_we, cfg_index, cfg_data) only while the block is idle.
// timing:
//   a hashing token passes through the back end as one issue step, one fold
//   per window token in every hash cell and three finalize steps; tokens that
//   do not hash never enter the back end, and a clear is applied on issue.
//   a read delivers one entry per cycle while rsp.ready is high.
//   a two-entry command queue lets the front end take requests while the
//   back end is busy.
// reset:
//   signature all ones, window empty, hash_seed 0, hash_count 64,
//   window_tokens 1.
// stall:
//   a low rsp.ready holds the current entry and pauses the readout.
`default_nettype none
module minhash_token_ngram_signature #(
    parameter int HASH_LANES = mtns_pkg::DEF_HASH_LANES,
    parameter int MAX_NGRAM  = mtns_pkg::DEF_MAX_NGRAM
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    mtns_req_if.sink                            req,
    mtns_rsp_if.source                          rsp,
    input  wire logic                           cfg_we,
    input  wire logic [mtns_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data
);
    import mtns_pkg::*;

    localparam int N_W   = $clog2(MAX_NGRAM + 1);
    localparam int CMD_W = 2 + N_W + MAX_NGRAM * 32;

    logic [31:0]         hash_seed_reg;
    logic [COUNT_W-1:0]  hash_count_reg;
    logic [WINDOW_W-1:0] window_tokens_reg;

    logic             f_valid;
    logic             f_ready;
    logic [CMD_W-1:0] f_data;
    logic             q_valid;
    logic             q_pop;
    logic [CMD_W-1:0] q_data;
    cell_ctrl_t       ctrl;
    logic [31:0]      k;
    logic [31:0]      len;
    logic [COUNT_W-1:0] cnt;
    logic [31:0]      sig [HASH_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg     <= '0;
            hash_count_reg    <= COUNT_W'(64);
            window_tokens_reg <= WINDOW_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_HASH_SEED:     hash_seed_reg     <= cfg_data;
                CFG_HASH_COUNT:    hash_count_reg    <= cfg_data[COUNT_W-1:0];
                CFG_WINDOW_TOKENS: window_tokens_reg <= cfg_data[WINDOW_W-1:0];
                default:           hash_seed_reg     <= hash_seed_reg;
            endcase
        end
    end

    mtns_front #(
        .MAX_NGRAM (MAX_NGRAM),
        .N_W       (N_W),
        .CMD_W     (CMD_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .window_tokens (window_tokens_reg),
        .cmd_valid     (f_valid),
        .cmd_ready     (f_ready),
        .cmd_data      (f_data)
    );

    mtns_cmd_fifo #(
        .WIDTH (CMD_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (q_data)
    );

    mtns_back #(
        .HASH_LANES (HASH_LANES),
        .MAX_NGRAM  (MAX_NGRAM),
        .N_W        (N_W),
        .CMD_W      (CMD_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_valid),
        .cmd_pop    (q_pop),
        .cmd_data   (q_data),
        .hash_count (hash_count_reg),
        .sig        (sig),
        .ctrl       (ctrl),
        .k          (k),
        .len        (len),
        .cnt        (cnt),
        .rsp        (rsp)
    );

    for (genvar j = 0; j < HASH_LANES; j++)
    begin : g_cell
        mtns_cell #(
            .J (j)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .k     (k),
            .seed  (hash_seed_reg),
            .len   (len),
            .cnt   (cnt),
            .sig   (sig[j])
        );
    end

endmodule
`default_nettype wire

// ----- sim/mtns_signature_checker.sv -----
// checker that predicts the minhash signature readout and compares every response transfer
`default_nettype none
module mtns_signature_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    mtns_req_if              req,
    mtns_rsp_if              rsp,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mtns_pkg::*;

    typedef struct {
        logic [5:0]  entry;
        logic [31:0] value;
        logic        last;
    } entry_result_t;

    logic [31:0] seed_reg;
    logic [6:0]  count_reg;
    logic [3:0]  window_reg;
    logic [31:0] signature [64];
    logic [31:0] window [8];
    int          fill;

    entry_result_t signature_readout [$];

    function automatic logic [31:0] rol(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] murmur_block(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] kk;
        kk = k * 32'hcc9e2d51;
        kk = rol(kk, 15);
        kk = kk * 32'h1b873593;
        return rol(h ^ kk, 13) * 32'd5 + 32'he6546b64;
    endfunction

    function automatic logic [31:0] murmur_final(input logic [31:0] h, input logic [31:0] len);
        logic [31:0] x;
        x = h ^ len;
        x = x ^ (x >> 16);
        x = x * 32'h85ebca6b;
        x = x ^ (x >> 13);
        x = x * 32'hc2b2ae35;
        return x ^ (x >> 16);
    endfunction

    function automatic int hashes_in_use();
        if (count_reg == 0) return 1;
        if (count_reg > 64) return 64;
        return count_reg;
    endfunction

    function automatic int ngram_len();
        if (window_reg == 0) return 1;
        if (window_reg > 8) return 8;
        return window_reg;
    endfunction

    task automatic absorb_token(input logic [31:0] tok);
        int          n;
        logic [31:0] h;
        for (int i = 0; i < 7; i++) window[i] = window[i + 1];
        window[7] = tok;
        if (fill < 8) fill++;
        n = ngram_len();
        if (fill < n) return;
        for (int j = 0; j < hashes_in_use(); j++)
        begin
            h = seed_reg + 32'(j);
            for (int i = 8 - n; i < 8; i++) h = murmur_block(h, window[i]);
            h = murmur_final(h, 32'(4 * n));
            if (h < signature[j]) signature[j] = h;
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        entry_result_t e;
        int            cnt;
        if (!rst_n)
        begin
            seed_reg   = '0;
            count_reg  = 7'd64;
            window_reg = 4'd1;
            fill       = 0;
            foreach (signature[i]) signature[i] = '1;
            foreach (window[i]) window[i] = '0;
            signature_readout.delete();
            errors     = 0;
            pending    = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (signature_readout.size() == 0)
                    report("unexpected transfer", rsp.min_value, '0);
                else
                begin
                    e = signature_readout.pop_front();
                    if (rsp.entry_index !== e.entry)
                        report("entry_index", 32'(rsp.entry_index), 32'(e.entry));
                    if (rsp.min_value !== e.value)
                        report("min_value", rsp.min_value, e.value);
                    if (rsp.last_entry !== e.last)
                        report("last_entry", 32'(rsp.last_entry), 32'(e.last));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_HASH_SEED:     seed_reg = cfg_data;
                    CFG_HASH_COUNT:    count_reg = cfg_data[6:0];
                    CFG_WINDOW_TOKENS: window_reg = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                case (req_kind_t'(req.req_type))
                    REQ_TOKEN:   absorb_token(req.token);
                    REQ_DOC_END:
                    begin
                        absorb_token(req.token);
                        fill = 0;
                    end
                    REQ_READ:
                    begin
                        cnt = hashes_in_use();
                        for (int j = 0; j < cnt; j++)
                        begin
                            e.entry = 6'(j);
                            e.value = signature[j];
                            e.last  = (j + 1 == cnt);
                            signature_readout.push_back(e);
                        end
                    end
                    default: foreach (signature[i]) signature[i] = '1;
                endcase
            end
            pending = signature_readout.size();
        end
    end
endmodule
`default_nettype wire

// ----- sim/tb_minhash_token_ngram_signature.sv -----
// testbench top: stimulus, configuration phases and verdict for the minhash signature block
`default_nettype none
module tb_minhash_token_ngram_signature;
    timeunit 1ns;
    timeprecision 1ps;

    import mtns_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = CFG_HASH_SEED;
    logic [31:0] cfg_data = '0;
    int          errors;
    int          pending;
    bit          gaps_on = 1;
    bit          hold_off = 0;

    mtns_req_if req();
    mtns_rsp_if rsp();

    minhash_token_ngram_signature dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    mtns_signature_checker chk (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        req.valid = 0;
        req.req_type = REQ_TOKEN;
        req.token = '0;
        rsp.ready = 0;
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                rsp.ready <= 0;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
                0: rsp.ready <= 1;
                1: rsp.ready <= $urandom_range(0, 1);
                default: rsp.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    int burst_left = 0;

    task automatic send(input req_kind_t kind, input logic [31:0] tok);
        if (gaps_on && burst_left == 0)
        begin
            req.valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        req.valid    <= 1;
        req.req_type <= kind;
        req.token    <= tok;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
    endtask

    task automatic settle();
        req.valid <= 0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 0;
    endtask

    task automatic random_stream(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 72) send(REQ_TOKEN, $urandom);
            else if (r < 84) send(REQ_DOC_END, $urandom);
            else if (r < 94) send(REQ_READ, $urandom);
            else send(REQ_CLEAR, $urandom);
        end
        send(REQ_READ, '0);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // defaults: window of one, all 64 hashes
        send(REQ_READ, '0);
        send(REQ_TOKEN, 32'h0000_0000);
        send(REQ_TOKEN, 32'hffff_ffff);
        send(REQ_DOC_END, 32'h8000_0001);
        send(REQ_READ, '0);
        send(REQ_CLEAR, 32'hffff_ffff);
        send(REQ_READ, '0);
        settle();

        write_reg(CFG_HASH_SEED, 32'hffff_ffff);
        write_reg(CFG_HASH_COUNT, 32'd1);
        write_reg(CFG_WINDOW_TOKENS, 32'd8);
        for (int i = 0; i < 9; i++) send(REQ_TOKEN, (i % 2) ? 32'hffff_ffff : 32'h0);
        send(REQ_DOC_END, 32'h5555_aaaa);
        send(REQ_TOKEN, 32'h1234_5678);
        send(REQ_READ, '0);
        settle();
        // window shrinks mid-document: no hash until enough tokens are held
        write_reg(CFG_WINDOW_TOKENS, 32'd3);
        send(REQ_TOKEN, 32'h0bad_f00d);
        send(REQ_TOKEN, 32'hdead_beef);
        send(REQ_READ, '0);
        settle();

        // out of range: zero acts as one
        write_reg(CFG_HASH_SEED, 32'h1234_5678);
        write_reg(CFG_HASH_COUNT, 32'd0);
        write_reg(CFG_WINDOW_TOKENS, 32'd0);
        random_stream(40);
        settle();

        // out of range: above the maximum saturates
        write_reg(CFG_HASH_SEED, $urandom);
        write_reg(CFG_HASH_COUNT, 32'd127);
        write_reg(CFG_WINDOW_TOKENS, 32'd15);
        gaps_on = 0;
        random_stream(45);
        settle();

        write_reg(CFG_HASH_SEED, $urandom);
        write_reg(CFG_HASH_COUNT, 32'd64);
        write_reg(CFG_WINDOW_TOKENS, 32'd3);
        gaps_on = 1;
        send(REQ_TOKEN, $urandom);
        send(REQ_TOKEN, $urandom);
        send(REQ_TOKEN, $urandom);
        hold_off = 1;
        send(REQ_READ, '0);
        for (int i = 0; i < 12; i++) send(REQ_TOKEN, $urandom);
        random_stream(45);
        settle();

        write_reg(CFG_HASH_SEED, $urandom);
        write_reg(CFG_HASH_COUNT, 32'd7);
        write_reg(CFG_WINDOW_TOKENS, 32'd1);
        random_stream(50);
        settle();

        write_reg(CFG_HASH_SEED, $urandom);
        write_reg(CFG_HASH_COUNT, $urandom_range(1, 64));
        write_reg(CFG_WINDOW_TOKENS, $urandom_range(1, 8));
        random_stream(50);
        settle();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
